### rtl/diff_drive_odometry_assert.svh
// assertion macros for the odometry block
// included by files that carry concurrent checks, no other dependencies
`ifndef DIFF_DRIVE_ODOMETRY_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_ASSERT_SVH

`ifndef SYNTHESIS
`define ODO_ASSERT_CK(name, ck, rn, prop) \
    name: assert property (@(posedge ck) disable iff (!rn) prop) \
        else $error("odometry check failed");
`define ODO_ASSERT(name, prop) `ODO_ASSERT_CK(name, clk, rst_n, prop)
`else
`define ODO_ASSERT_CK(name, ck, rn, prop)
`define ODO_ASSERT(name, prop)
`endif

`endif

### rtl/odo_pkg.sv
// shared types and constants for the odometry block
// no dependencies
package odo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATION_SCALE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION_GAIN     = CFG_IDX_W'(1);

    localparam logic [15:0] TRANSLATION_SCALE_RST = 16'd655;
    localparam logic [15:0] ROTATION_GAIN_RST     = 16'd19661;

    localparam logic signed [30:0] PI_Q28      = 31'sd843314857;
    localparam logic signed [30:0] HALF_PI_Q28 = 31'sd421657428;
    localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    localparam logic [29:0] ATAN_Q30 [32] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127,
        30'd63,        30'd31,        30'd15,        30'd8,
        30'd4,         30'd2,         30'd1,         30'd0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_ROTATE,
        ST_EMIT
    } odo_state_t;

endpackage

### rtl/odo_wheel_if.sv
// wheel reading channel, valid/ready
// no dependencies
interface odo_wheel_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] wheel_left_pos;
    logic signed [31:0] wheel_right_pos;

    modport source (output valid, output wheel_left_pos, output wheel_right_pos, input ready);
    modport sink (input valid, input wheel_left_pos, input wheel_right_pos, output ready);
endinterface

### rtl/odo_pose_if.sv
// pose result channel, valid/ready
// no dependencies
interface odo_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [30:0] pose_heading;

    modport source (output valid, output pose_x, output pose_y, output pose_heading,
                    input ready);
    modport sink (input valid, input pose_x, input pose_y, input pose_heading,
                  output ready);
endinterface

### rtl/odo_cfg_if.sv
// configuration write channel, valid/ready
// depends on odo_pkg
interface odo_cfg_if
    import odo_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [15:0]          data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/odo_serial_mul.sv
// bit-serial signed multiplier, one multiplier bit per cycle
// no dependencies
module odo_serial_mul #(
    parameter int AW = 34,
    parameter int BW = 17
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [AW-1:0]    a,
    input  logic signed [BW-1:0]    b,
    output logic                    busy,
    output logic signed [AW+BW-1:0] product
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic signed [PW-1:0] a_sh_reg;
    logic [BW-1:0]        b_sh_reg;
    logic signed [PW-1:0] acc_reg;
    logic signed [PW-1:0] acc_next;
    logic                 last;

    assign last = (cnt_reg == CW'(BW - 1));

    always_comb
    begin
        acc_next = acc_reg;
        if (b_sh_reg[0])
        begin
            if (last)
                acc_next = acc_reg - a_sh_reg;
            else
                acc_next = acc_reg + a_sh_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (last)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_sh_reg <= {{BW{a[AW-1]}}, a};
            b_sh_reg <= b;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_next;
            a_sh_reg <= a_sh_reg <<< 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign busy    = busy_reg;
    assign product = acc_reg;
endmodule

### rtl/odo_cordic.sv
// iterative cordic rotation, one micro-rotation per cycle, gives cos and sin in q1.28
// depends on odo_pkg
module odo_cordic
    import odo_pkg::*;
#(
    parameter int STEPS = CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [30:0] heading,
    output logic               busy,
    output logic signed [29:0] cos_q28,
    output logic signed [29:0] sin_q28
);
    localparam int CW = $clog2(STEPS + 1);

    logic                 busy_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 flip_reg;
    logic signed [32:0]   x_reg;
    logic signed [32:0]   y_reg;
    logic signed [32:0]   z_reg;
    logic signed [32:0]   xs;
    logic signed [32:0]   ys;
    logic signed [32:0]   ang;
    logic signed [30:0]   h_fold;
    logic                 flip;
    logic signed [32:0]   x_rnd;
    logic signed [32:0]   y_rnd;
    logic                 last;

    assign last = (cnt_reg == CW'(STEPS - 1));

    always_comb
    begin
        h_fold = heading;
        flip   = 1'b0;
        if (heading > HALF_PI_Q28)
        begin
            h_fold = heading - PI_Q28;
            flip   = 1'b1;
        end
        else if (heading < -HALF_PI_Q28)
        begin
            h_fold = heading + PI_Q28;
            flip   = 1'b1;
        end
    end

    assign xs  = x_reg >>> cnt_reg;
    assign ys  = y_reg >>> cnt_reg;
    assign ang = 33'(ATAN_Q30[5'(cnt_reg)]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (last)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= CORDIC_GAIN_Q30;
            y_reg    <= '0;
            z_reg    <= {h_fold, 2'b00};
            flip_reg <= flip;
        end
        else if (busy_reg)
        begin
            if (!z_reg[32])
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - ang;
            end
            else
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + ang;
            end
        end
    end

    assign x_rnd = (x_reg + 33'sd2) >>> 2;
    assign y_rnd = (y_reg + 33'sd2) >>> 2;

    assign busy    = busy_reg;
    assign cos_q28 = flip_reg ? -x_rnd[29:0] : x_rnd[29:0];
    assign sin_q28 = flip_reg ? -y_rnd[29:0] : y_rnd[29:0];
endmodule

### rtl/diff_drive_odometry.sv
// differential drive odometry, top level: sequencer, pose state and config registers
// depends on odo_pkg, the channel interfaces, odo_serial_mul, odo_cordic
//
// A primed reading runs the 17-bit bit-serial scale multipliers beside the CORDIC, then the
// 30-bit bit-serial rotation multipliers, then waits in the emit state for the output
// register. The first reading after reset only primes the stored pair and goes straight
// to the emit state. One reading is worked on at a time; a finished pose sits in the
// output register while the next one is taken.
`include "diff_drive_odometry_assert.svh"

module diff_drive_odometry
    import odo_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    odo_wheel_if.sink  wheel,
    odo_pose_if.source pose,
    odo_cfg_if.sink    cfg
);
    odo_state_t state_reg, state_next;

    logic [15:0]        translation_scale_reg;
    logic [15:0]        rotation_gain_reg;
    logic signed [31:0] left_last_reg;
    logic signed [31:0] right_last_reg;
    logic signed [31:0] pos_x_reg;
    logic signed [31:0] pos_y_reg;
    logic signed [30:0] heading_reg;
    logic               primed_reg;

    logic               pose_valid_reg;
    logic signed [31:0] pose_x_reg;
    logic signed [31:0] pose_y_reg;
    logic signed [30:0] pose_heading_reg;

    logic in_beat;
    logic start_scale;
    logic start_rot;
    logic emit;

    logic signed [32:0] dl, dr;
    logic signed [33:0] dsum, ddiff;

    logic               tmul_busy, hmul_busy, cor_busy, xmul_busy, ymul_busy;
    logic signed [50:0] tprod, hprod, tprod_r, hprod_r;
    logic signed [63:0] xprod, yprod, xprod_r, yprod_r;
    logic signed [33:0] trans;
    logic signed [29:0] dh;
    logic signed [29:0] cos_q28, sin_q28;
    logic signed [35:0] xinc, yinc;
    logic signed [32:0] hsum, hwrap;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        if (v > 37'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -37'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    assign in_beat     = wheel.valid && wheel.ready;
    assign wheel.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        start_scale = 1'b0;
        start_rot   = 1'b0;
        emit        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    if (primed_reg)
                    begin
                        start_scale = 1'b1;
                        state_next  = ST_SCALE;
                    end
                    else
                        state_next = ST_EMIT;
                end
            end
            ST_SCALE:
            begin
                if (!tmul_busy && !hmul_busy && !cor_busy)
                begin
                    start_rot  = 1'b1;
                    state_next = ST_ROTATE;
                end
            end
            ST_ROTATE:
            begin
                if (!xmul_busy && !ymul_busy)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!pose_valid_reg || pose.ready)
                begin
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // wheel deltas
    assign dl    = 33'(wheel.wheel_left_pos) - 33'(left_last_reg);
    assign dr    = 33'(wheel.wheel_right_pos) - 33'(right_last_reg);
    assign dsum  = 34'(dl) + 34'(dr);
    assign ddiff = 34'(dl) - 34'(dr);

    odo_serial_mul #(.AW(34), .BW(17)) u_tmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_scale),
        .a       (dsum),
        .b       ({1'b0, translation_scale_reg}),
        .busy    (tmul_busy),
        .product (tprod)
    );

    odo_serial_mul #(.AW(34), .BW(17)) u_hmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_scale),
        .a       (ddiff),
        .b       ({1'b0, rotation_gain_reg}),
        .busy    (hmul_busy),
        .product (hprod)
    );

    odo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_scale),
        .heading (heading_reg),
        .busy    (cor_busy),
        .cos_q28 (cos_q28),
        .sin_q28 (sin_q28)
    );

    assign tprod_r = tprod + 51'sd32768;
    assign hprod_r = hprod + 51'sd524288;
    assign trans   = tprod_r[49:16];
    assign dh      = hprod_r[49:20];

    odo_serial_mul #(.AW(34), .BW(30)) u_xmul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_rot),
        .a       (trans),
        .b       (cos_q28),
        .busy    (xmul_busy),
        .product (xprod)
    );

    odo_serial_mul #(.AW(34), .BW(30)) u_ymul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_rot),
        .a       (trans),
        .b       (sin_q28),
        .busy    (ymul_busy),
        .product (yprod)
    );

    assign xprod_r = xprod + 64'sd134217728;
    assign yprod_r = yprod + 64'sd134217728;
    assign xinc    = xprod_r[63:28];
    assign yinc    = yprod_r[63:28];

    // heading wrap into [-pi, pi)
    assign hsum = 33'(heading_reg) + 33'(dh) + 33'(PI_Q28);
    always_comb
    begin
        priority if (hsum < 33'sd0)
            hwrap = hsum + TWO_PI_Q28;
        else if (hsum >= TWO_PI_Q28)
            hwrap = hsum - TWO_PI_Q28;
        else
            hwrap = hsum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            translation_scale_reg <= TRANSLATION_SCALE_RST;
            rotation_gain_reg     <= ROTATION_GAIN_RST;
            left_last_reg         <= '0;
            right_last_reg        <= '0;
            pos_x_reg             <= '0;
            pos_y_reg             <= '0;
            heading_reg           <= '0;
            primed_reg            <= 1'b0;
            pose_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_TRANSLATION_SCALE:
                        translation_scale_reg <= cfg.data;
                    CFG_ROTATION_GAIN:
                        rotation_gain_reg <= cfg.data;
                    default:
                    begin
                    end
                endcase
            end
            if (in_beat)
            begin
                left_last_reg  <= wheel.wheel_left_pos;
                right_last_reg <= wheel.wheel_right_pos;
                primed_reg     <= 1'b1;
            end
            if (start_rot)
                heading_reg <= 31'(hwrap - 33'(PI_Q28));
            if (state_reg == ST_ROTATE && state_next == ST_EMIT)
            begin
                pos_x_reg <= sat32(37'(pos_x_reg) + 37'(xinc));
                pos_y_reg <= sat32(37'(pos_y_reg) + 37'(yinc));
            end
            if (emit)
                pose_valid_reg <= 1'b1;
            else if (pose.ready)
                pose_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pose_x_reg       <= pos_x_reg;
            pose_y_reg       <= pos_y_reg;
            pose_heading_reg <= heading_reg;
        end
    end

    assign pose.valid        = pose_valid_reg;
    assign pose.pose_x       = pose_x_reg;
    assign pose.pose_y       = pose_y_reg;
    assign pose.pose_heading = pose_heading_reg;

    `ODO_ASSERT(a_heading_range, (heading_reg >= -PI_Q28) && (heading_reg < PI_Q28))
    `ODO_ASSERT(a_emit_from_state, $rose(pose_valid_reg) |-> $past(state_reg == ST_EMIT))
    `ODO_ASSERT(a_mul_busy_state, (tmul_busy || xmul_busy) |-> (state_reg != ST_IDLE))
    `ODO_ASSERT(a_unprimed_skip, (in_beat && !primed_reg) |=> (state_reg == ST_EMIT && !cor_busy))
endmodule

### tb/sv/diff_drive_odometry_tb.sv
// testbench for diff_drive_odometry: drives wheel readings and register writes,
// predicts every pose beat and compares it field by field
// depends on odo_pkg, odo_wheel_if, odo_pose_if, odo_cfg_if and the block itself
`timescale 1ns / 1ps

module diff_drive_odometry_tb;
    import odo_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = CFG_IDX_W'(7);

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [30:0] h;
    } pose_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    odo_wheel_if wheel_ch ();
    odo_pose_if  pose_ch ();
    odo_cfg_if   cfg_ch ();

    diff_drive_odometry DUT (
        .clk  (clk),
        .rst_n(rst_n),
        .wheel(wheel_ch),
        .pose (pose_ch),
        .cfg  (cfg_ch)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [15:0] trans_scale;
    logic [15:0] rot_gain;
    longint      left_prev, right_prev, x_acc, y_acc, head_acc;
    bit          is_primed;

    pose_t pending_poses[$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    send_idle_pct = 0;
    int    stall_pct = 0;
    bit    hold_out = 1'b0;
    longint cur_l = 0, cur_r = 0;

    function automatic longint rshift_round(longint v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic heading_sincos(input longint h, output longint c, output longint s);
        longint xr, yr, z, xs, ys;
        bit flip;
        xr = CORDIC_GAIN_Q30;
        yr = 0;
        flip = 1'b0;
        if (h > HALF_PI_Q28)
        begin
            h -= PI_Q28;
            flip = 1'b1;
        end
        else if (h < -HALF_PI_Q28)
        begin
            h += PI_Q28;
            flip = 1'b1;
        end
        z = h * 4;
        for (int i = 0; i < CORDIC_STEPS_DEF; i++)
        begin
            xs = xr >>> i;
            ys = yr >>> i;
            if (z >= 0)
            begin
                xr -= ys;
                yr += xs;
                z -= longint'(ATAN_Q30[i]);
            end
            else
            begin
                xr += ys;
                yr -= xs;
                z += longint'(ATAN_Q30[i]);
            end
        end
        xr = rshift_round(xr, 2);
        yr = rshift_round(yr, 2);
        c = flip ? -xr : xr;
        s = flip ? -yr : yr;
    endtask

    task automatic advance_pose(input logic signed [31:0] l_in, input logic signed [31:0] r_in);
        longint l, r, dl, dr, t, dh, c, s, h;
        pose_t p;
        l = l_in;
        r = r_in;
        if (is_primed)
        begin
            dl = l - left_prev;
            dr = r - right_prev;
            t = rshift_round((dl + dr) * longint'(trans_scale), 16);
            dh = rshift_round((dl - dr) * longint'(rot_gain), 20);
            heading_sincos(head_acc, c, s);
            x_acc = clamp32(x_acc + rshift_round(t * c, 28));
            y_acc = clamp32(y_acc + rshift_round(t * s, 28));
            h = (head_acc + dh + PI_Q28) % TWO_PI_Q28;
            if (h < 0)
                h += TWO_PI_Q28;
            head_acc = h - PI_Q28;
        end
        left_prev = l;
        right_prev = r;
        is_primed = 1'b1;
        p.x = x_acc[31:0];
        p.y = y_acc[31:0];
        p.h = head_acc[30:0];
        pending_poses.push_back(p);
    endtask

    task automatic send_reading(input logic signed [31:0] l, input logic signed [31:0] r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            wheel_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        wheel_ch.valid <= 1'b1;
        wheel_ch.wheel_left_pos <= l;
        wheel_ch.wheel_right_pos <= r;
        do
            @(posedge clk);
        while (!wheel_ch.ready);
        advance_pose(l, r);
    endtask

    task automatic wait_drained();
        wheel_ch.valid <= 1'b0;
        while (pending_poses.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == CFG_TRANSLATION_SCALE)
            trans_scale = val;
        else if (idx == CFG_ROTATION_GAIN)
            rot_gain = val;
        @(posedge clk);
    endtask

    // wheel motion: mostly small steps, sometimes a jump anywhere in range
    task automatic send_motion();
        if ($urandom_range(19) == 0)
        begin
            cur_l = $signed($urandom());
            cur_r = $signed($urandom());
        end
        else
        begin
            cur_l = longint'(signed'(32'(cur_l + $signed($urandom_range(400000)) - 200000)));
            cur_r = longint'(signed'(32'(cur_r + $signed($urandom_range(400000)) - 200000)));
        end
        send_reading(cur_l[31:0], cur_r[31:0]);
    endtask

    // result check
    always @(posedge clk)
    begin
        pose_t e;
        if (rst_n && pose_ch.valid && pose_ch.ready)
        begin
            if (pending_poses.size() == 0)
            begin
                errors++;
                $display("%0t unexpected pose beat x=%0d y=%0d h=%0d", $time,
                         pose_ch.pose_x, pose_ch.pose_y, pose_ch.pose_heading);
            end
            else
            begin
                e = pending_poses.pop_front();
                if (pose_ch.pose_x !== e.x)
                begin
                    errors++;
                    $display("%0t pose_x expected %0d actual %0d", $time, e.x, pose_ch.pose_x);
                end
                if (pose_ch.pose_y !== e.y)
                begin
                    errors++;
                    $display("%0t pose_y expected %0d actual %0d", $time, e.y, pose_ch.pose_y);
                end
                if (pose_ch.pose_heading !== e.h)
                begin
                    errors++;
                    $display("%0t pose_heading expected %0d actual %0d", $time, e.h,
                             pose_ch.pose_heading);
                end
            end
        end
        pose_ch.ready <= !hold_out && ($urandom_range(99) >= stall_pct);
    end

    // watchdog on cycles with no beat on any channel
    always @(posedge clk)
    begin
        if ((wheel_ch.valid && wheel_ch.ready) || (pose_ch.valid && pose_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_priming();
        send_reading(32'sh7fffffff, -32'sh80000000);
        send_reading(32'sh7fffffff, -32'sh80000000);
        send_reading(32'sh00010000, 32'sh00010000);
        send_reading(32'sh00020000, 32'sh00010000);
    endtask

    task automatic test_extremes();
        write_reg(CFG_TRANSLATION_SCALE, 16'hffff);
        write_reg(CFG_ROTATION_GAIN, 16'hffff);
        for (int i = 0; i < 4; i++)
        begin
            send_reading(-32'sh80000000, 32'sh7fffffff);
            send_reading(32'sh7fffffff, -32'sh80000000);
        end
        send_reading(32'sh7fffffff, 32'sh7fffffff);
        send_reading(-32'sh80000000, -32'sh80000000);
        send_reading(32'sh7fffffff, 32'sh7fffffff);
        write_reg(CFG_UNUSED_IDX, 16'h0000);
        send_reading(32'sh00000000, 32'sh00000000);
        write_reg(CFG_TRANSLATION_SCALE, 16'h0000);
        write_reg(CFG_ROTATION_GAIN, 16'h0000);
        send_reading(32'sh12345678, -32'sh1234567);
        send_reading(-32'sh1, 32'sh1);
    endtask

    task automatic test_random_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        write_reg(CFG_TRANSLATION_SCALE, 16'($urandom()));
        write_reg(CFG_ROTATION_GAIN, 16'($urandom()));
        repeat (n) send_motion();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct = 0;
        fork
            begin
                hold_out = 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_out = 1'b0;
            end
            repeat (12) send_motion();
        join
    endtask

    initial
    begin
        trans_scale = TRANSLATION_SCALE_RST;
        rot_gain = ROTATION_GAIN_RST;
        left_prev = 0;
        right_prev = 0;
        x_acc = 0;
        y_acc = 0;
        head_acc = 0;
        is_primed = 1'b0;
        wheel_ch.valid = 1'b0;
        wheel_ch.wheel_left_pos = '0;
        wheel_ch.wheel_right_pos = '0;
        pose_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_priming();
        test_extremes();
        test_random_phase(300, 0, 0);
        test_random_phase(300, 67, 0);
        test_random_phase(300, 0, 67);
        test_random_phase(300, 29, 29);
        test_backpressure();
        test_random_phase(60, 10, 10);

        wait_drained();
        repeat (100) @(posedge clk);
        if (errors == 0 && pending_poses.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
